@@ design/padsag_pkg.sv @@
// Shared widths, configuration types and a helper function for the pad source address generator.
`timescale 1ns / 1ps
`default_nettype none

package padsag_pkg;

    // Field widths
    localparam int PLANE_W    = 16;
    localparam int POS_W      = 12;
    localparam int SRC_W      = 10;
    localparam int OFF_W      = 46;
    localparam int EXT_W      = 11;
    localparam int HW_W       = 21;
    localparam int DHW_W      = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Limits on extents and planes
    localparam int MAX_EXTENT = 1024;
    localparam int MAX_PLANES = 65536;

    // Padding modes
    localparam logic MODE_REPLICATE = 1'b0;
    localparam logic MODE_REFLECT   = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAD_MODE   = 3'd0,
        CFG_PAD_DEPTH  = 3'd1,
        CFG_PAD_HEIGHT = 3'd2,
        CFG_PAD_WIDTH  = 3'd3,
        CFG_SRC_DEPTH  = 3'd4,
        CFG_SRC_HEIGHT = 3'd5,
        CFG_SRC_WIDTH  = 3'd6
    } t_cfg_idx;

    // Decoded configuration seen by the datapath
    typedef struct packed {
        logic                    reflect;
        logic signed [EXT_W-1:0] pad_d;
        logic signed [EXT_W-1:0] pad_h;
        logic signed [EXT_W-1:0] pad_w;
        logic [EXT_W-1:0]        dsz;
        logic [EXT_W-1:0]        hsz;
        logic [EXT_W-1:0]        wsz;
        logic [HW_W-1:0]         hw;
        logic [DHW_W-1:0]        dhw;
    } t_cfg;

    // Load enables for the offset stages
    typedef struct packed {
        logic s2;
        logic s3;
    } t_pipe_en;

    // Zero extent counts as one, oversize extent saturates
    function automatic logic [EXT_W-1:0] fix_ext(input logic [EXT_W-1:0] v);
        logic [EXT_W-1:0] r;
        if (v == '0) begin
            r = EXT_W'(1);
        end else if (32'(v) > MAX_EXTENT) begin
            r = EXT_W'(MAX_EXTENT);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/padsag_in_if.sv @@
// Input channel: one output coordinate per item.
`timescale 1ns / 1ps
`default_nettype none

interface padsag_in_if;
    import padsag_pkg::*;

    logic               valid;
    logic               ready;
    logic [PLANE_W-1:0] plane;
    logic [POS_W-1:0]   out_depth_pos;
    logic [POS_W-1:0]   out_height_pos;
    logic [POS_W-1:0]   out_width_pos;

    modport source (
        output valid, plane, out_depth_pos, out_height_pos, out_width_pos,
        input  ready
    );

    modport sink (
        input  valid, plane, out_depth_pos, out_height_pos, out_width_pos,
        output ready
    );
endinterface

`default_nettype wire

@@ design/padsag_out_if.sv @@
// Output channel: source coordinate and linear offset per item.
`timescale 1ns / 1ps
`default_nettype none

interface padsag_out_if;
    import padsag_pkg::*;

    logic             valid;
    logic             ready;
    logic [SRC_W-1:0] src_depth_pos;
    logic [SRC_W-1:0] src_height_pos;
    logic [SRC_W-1:0] src_width_pos;
    logic [OFF_W-1:0] src_offset;

    modport source (
        output valid, src_depth_pos, src_height_pos, src_width_pos, src_offset,
        input  ready
    );

    modport sink (
        input  valid, src_depth_pos, src_height_pos, src_width_pos, src_offset,
        output ready
    );
endinterface

`default_nettype wire

@@ design/padsag_cfg.sv @@
// Configuration registers with extent fix-up and precomputed plane strides.
`timescale 1ns / 1ps
`default_nettype none

module padsag_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_we,
    input  wire logic [padsag_pkg::CFG_IDX_W-1:0]   i_idx,
    input  wire logic [padsag_pkg::CFG_DATA_W-1:0]  i_data,
    output padsag_pkg::t_cfg                        o_cfg
);
    import padsag_pkg::*;

    logic                    r_mode;
    logic signed [EXT_W-1:0] r_pad_d;
    logic signed [EXT_W-1:0] r_pad_h;
    logic signed [EXT_W-1:0] r_pad_w;
    logic [EXT_W-1:0]        r_dsz;
    logic [EXT_W-1:0]        r_hsz;
    logic [EXT_W-1:0]        r_wsz;
    logic [HW_W-1:0]         r_hw;
    logic [DHW_W-1:0]        r_dhw;
    logic [HW_W-1:0]         n_hw;
    logic [DHW_W-1:0]        n_dhw;

    // Register writes; extents are stored already fixed up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_REPLICATE;
            r_pad_d <= '0;
            r_pad_h <= '0;
            r_pad_w <= '0;
            r_dsz   <= EXT_W'(1);
            r_hsz   <= EXT_W'(1);
            r_wsz   <= EXT_W'(1);
        end else if (i_we) begin
            unique case (t_cfg_idx'(i_idx))
                CFG_PAD_MODE:   r_mode  <= i_data[0];
                CFG_PAD_DEPTH:  r_pad_d <= signed'(i_data[EXT_W-1:0]);
                CFG_PAD_HEIGHT: r_pad_h <= signed'(i_data[EXT_W-1:0]);
                CFG_PAD_WIDTH:  r_pad_w <= signed'(i_data[EXT_W-1:0]);
                CFG_SRC_DEPTH:  r_dsz   <= fix_ext(i_data[EXT_W-1:0]);
                CFG_SRC_HEIGHT: r_hsz   <= fix_ext(i_data[EXT_W-1:0]);
                CFG_SRC_WIDTH:  r_wsz   <= fix_ext(i_data[EXT_W-1:0]);
                default: ;
            endcase
        end
    end

    // Strides: H*W is registered from the stored extents, D*H*W from the registered H*W
    assign n_hw  = HW_W'(r_hsz) * HW_W'(r_wsz);
    assign n_dhw = DHW_W'(r_dsz) * DHW_W'(r_hw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw  <= HW_W'(1);
            r_dhw <= DHW_W'(1);
        end else begin
            r_hw  <= n_hw;
            r_dhw <= n_dhw;
        end
    end

    assign o_cfg.reflect = r_mode;
    assign o_cfg.pad_d   = r_pad_d;
    assign o_cfg.pad_h   = r_pad_h;
    assign o_cfg.pad_w   = r_pad_w;
    assign o_cfg.dsz     = r_dsz;
    assign o_cfg.hsz     = r_hsz;
    assign o_cfg.wsz     = r_wsz;
    assign o_cfg.hw      = r_hw;
    assign o_cfg.dhw     = r_dhw;

endmodule

`default_nettype wire

@@ design/padsag_axis_map.sv @@
// Maps one output axis position to its source position (replicate or reflect, crop).
`timescale 1ns / 1ps
`default_nettype none

module padsag_axis_map (
    input  wire logic [padsag_pkg::POS_W-1:0]        i_pos,
    input  wire logic signed [padsag_pkg::EXT_W-1:0] i_pad,
    input  wire logic [padsag_pkg::EXT_W-1:0]        i_size,
    input  wire logic                                i_reflect,
    output logic [padsag_pkg::SRC_W-1:0]             o_src
);
    import padsag_pkg::*;

    // Signed working width covers +-(4095 + 2*1024)
    localparam int AW = 15;
    localparam logic signed [AW-1:0] ZERO = '0;
    localparam logic signed [AW-1:0] ONE  = AW'(1);
    localparam logic signed [AW-1:0] TWO  = AW'(2);

    logic signed [AW-1:0] j;
    logic signed [AW-1:0] p;
    logic signed [AW-1:0] s;
    logic signed [AW-1:0] lim;
    logic signed [AW-1:0] v;
    logic signed [AW-1:0] c;

    assign j   = signed'(AW'(i_pos));
    assign p   = AW'(i_pad);
    assign s   = signed'(AW'(i_size));
    assign lim = s - ONE;

    // Map with the crop shift (-pad) already folded in
    always_comb begin
        priority if (j < p) begin
            v = i_reflect ? (p - j) : ZERO;
        end else if (j < s + p) begin
            v = j - p;
        end else begin
            v = i_reflect ? (s + s + p - TWO - j) : lim;
        end
    end

    // Saturate to the source extent
    always_comb begin
        priority if (v < ZERO) begin
            c = ZERO;
        end else if (v > lim) begin
            c = lim;
        end else begin
            c = v;
        end
    end

    assign o_src = c[SRC_W-1:0];

endmodule

`default_nettype wire

@@ design/padsag_offset.sv @@
// Offset stages: stride products, then the final sum of the linear offset.
`timescale 1ns / 1ps
`default_nettype none

module padsag_offset (
    input  wire logic                             i_clk,
    input  wire padsag_pkg::t_pipe_en             i_en,
    input  wire logic [padsag_pkg::PLANE_W-1:0]   i_plane,
    input  wire logic [padsag_pkg::SRC_W-1:0]     i_sd,
    input  wire logic [padsag_pkg::SRC_W-1:0]     i_sh,
    input  wire logic [padsag_pkg::SRC_W-1:0]     i_sw,
    input  wire logic [padsag_pkg::EXT_W-1:0]     i_wsz,
    input  wire logic [padsag_pkg::HW_W-1:0]      i_hw,
    input  wire logic [padsag_pkg::DHW_W-1:0]     i_dhw,
    output logic [padsag_pkg::SRC_W-1:0]          o_sd,
    output logic [padsag_pkg::SRC_W-1:0]          o_sh,
    output logic [padsag_pkg::SRC_W-1:0]          o_sw,
    output logic [padsag_pkg::OFF_W-1:0]          o_offset
);
    import padsag_pkg::*;

    localparam int PP_W = PLANE_W + DHW_W;
    localparam int PD_W = SRC_W + HW_W;
    localparam int PH_W = SRC_W + EXT_W;

    logic [PP_W-1:0]  r_pp;
    logic [PD_W-1:0]  r_pd;
    logic [PH_W-1:0]  r_ph;
    logic [SRC_W-1:0] r_s2_sd;
    logic [SRC_W-1:0] r_s2_sh;
    logic [SRC_W-1:0] r_s2_sw;
    logic [OFF_W-1:0] n_off;
    logic [OFF_W-1:0] r_off;
    logic [SRC_W-1:0] r_s3_sd;
    logic [SRC_W-1:0] r_s3_sh;
    logic [SRC_W-1:0] r_s3_sw;

    // Stage 2: three independent products
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_pp    <= PP_W'(i_plane) * PP_W'(i_dhw);
            r_pd    <= PD_W'(i_sd) * PD_W'(i_hw);
            r_ph    <= PH_W'(i_sh) * PH_W'(i_wsz);
            r_s2_sd <= i_sd;
            r_s2_sh <= i_sh;
            r_s2_sw <= i_sw;
        end
    end

    // Stage 3: sum modulo the offset width
    assign n_off = OFF_W'(r_pp) + OFF_W'(r_pd) + OFF_W'(r_ph) + OFF_W'(r_s2_sw);

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_off   <= n_off;
            r_s3_sd <= r_s2_sd;
            r_s3_sh <= r_s2_sh;
            r_s3_sw <= r_s2_sw;
        end
    end

    assign o_sd     = r_s3_sd;
    assign o_sh     = r_s3_sh;
    assign o_sw     = r_s3_sw;
    assign o_offset = r_off;

endmodule

`default_nettype wire

@@ design/pad_source_address_gen_unit.sv @@
// Top level of the pad source address generator: config, pipeline control, stages.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------------
//  i_in     | in  | valid / ready      | plane, out_depth_pos, out_height_pos, out_width_pos
//  o_out    | out | valid / ready      | src_depth/height/width_pos, src_offset
//  i_cfg_*  | in  | i_cfg_we, no wait  | i_cfg_idx, i_cfg_data
//
//  One item per cycle while o_out does not stall; the accept loads the input register, then
//  the item moves through the axis-map, product and sum registers to o_out.valid.
//  The strides H*W and then D*H*W are registered after a configuration write.
//  Reset (synchronous, active low) empties the pipeline and loads the register defaults.
//  A stall at o_out holds each full stage; empty stages still fill, so i_in.ready drops
//  only once all four stages are full.
`timescale 1ns / 1ps
`default_nettype none

module pad_source_address_gen_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    padsag_in_if.sink                               i_in,
    padsag_out_if.source                            o_out,
    input  wire logic                               i_cfg_we,
    input  wire logic [padsag_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [padsag_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import padsag_pkg::*;

    t_cfg     cfg;
    t_pipe_en pipe_en;

    logic rdy0, rdy1, rdy2, rdy3;
    logic r_s0_v, r_s1_v, r_s2_v, r_s3_v;

    logic [PLANE_W-1:0] n_s0_plane;
    logic [PLANE_W-1:0] r_s0_plane;
    logic [POS_W-1:0]   r_s0_od;
    logic [POS_W-1:0]   r_s0_oh;
    logic [POS_W-1:0]   r_s0_ow;

    logic [SRC_W-1:0]   map_sd;
    logic [SRC_W-1:0]   map_sh;
    logic [SRC_W-1:0]   map_sw;
    logic [PLANE_W-1:0] r_s1_plane;
    logic [SRC_W-1:0]   r_s1_sd;
    logic [SRC_W-1:0]   r_s1_sh;
    logic [SRC_W-1:0]   r_s1_sw;

    // Configuration
    padsag_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Stage ready chain: a stage loads when empty or when it drains
    assign rdy3 = !r_s3_v || o_out.ready;
    assign rdy2 = !r_s2_v || rdy3;
    assign rdy1 = !r_s1_v || rdy2;
    assign rdy0 = !r_s0_v || rdy1;

    assign i_in.ready = rdy0;
    assign pipe_en.s2 = rdy2;
    assign pipe_en.s3 = rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (rdy0) r_s0_v <= i_in.valid;
            if (rdy1) r_s1_v <= r_s0_v;
            if (rdy2) r_s2_v <= r_s1_v;
            if (rdy3) r_s3_v <= r_s2_v;
        end
    end

    // Stage 0: input register with plane saturation
    assign n_s0_plane = (32'(i_in.plane) >= MAX_PLANES) ? PLANE_W'(MAX_PLANES - 1)
                                                        : i_in.plane;

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_s0_plane <= n_s0_plane;
            r_s0_od    <= i_in.out_depth_pos;
            r_s0_oh    <= i_in.out_height_pos;
            r_s0_ow    <= i_in.out_width_pos;
        end
    end

    // Stage 1: per-axis padding map
    padsag_axis_map u_map_d (
        .i_pos     (r_s0_od),
        .i_pad     (cfg.pad_d),
        .i_size    (cfg.dsz),
        .i_reflect (cfg.reflect),
        .o_src     (map_sd)
    );

    padsag_axis_map u_map_h (
        .i_pos     (r_s0_oh),
        .i_pad     (cfg.pad_h),
        .i_size    (cfg.hsz),
        .i_reflect (cfg.reflect),
        .o_src     (map_sh)
    );

    padsag_axis_map u_map_w (
        .i_pos     (r_s0_ow),
        .i_pad     (cfg.pad_w),
        .i_size    (cfg.wsz),
        .i_reflect (cfg.reflect),
        .o_src     (map_sw)
    );

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_plane <= r_s0_plane;
            r_s1_sd    <= map_sd;
            r_s1_sh    <= map_sh;
            r_s1_sw    <= map_sw;
        end
    end

    // Stages 2 and 3: linear offset
    padsag_offset u_offset (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_plane  (r_s1_plane),
        .i_sd     (r_s1_sd),
        .i_sh     (r_s1_sh),
        .i_sw     (r_s1_sw),
        .i_wsz    (cfg.wsz),
        .i_hw     (cfg.hw),
        .i_dhw    (cfg.dhw),
        .o_sd     (o_out.src_depth_pos),
        .o_sh     (o_out.src_height_pos),
        .o_sw     (o_out.src_width_pos),
        .o_offset (o_out.src_offset)
    );

    assign o_out.valid = r_s3_v;

    // An accepted item always lands in stage 0
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_s0_v)
        else $error("accepted item did not enter stage 0");

    // Back-pressure reaches the input only with every stage full
    a_full_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s0_v && r_s1_v && r_s2_v && r_s3_v))
        else $error("input stalled with an empty stage");

    // A stage that cannot drain keeps its item and the one ahead stays full
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !rdy2) |=> (r_s1_v && r_s2_v && r_s3_v))
        else $error("stalled stage 1 item lost");

    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && rdy3) |=> r_s3_v)
        else $error("stage 2 item did not reach output");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench for the pad source address generator: directed edge cases, random configs, stalls.
`timescale 1ns / 1ps

module tb_top;
    import padsag_pkg::*;

    localparam int PIPE_LATENCY = 4;
    localparam int IDLE_LIMIT   = 5000;
    localparam int MAX_REPORTS  = 10;

    // One output coordinate as sent on the input channel
    typedef struct packed {
        logic [PLANE_W-1:0] plane;
        logic [POS_W-1:0]   out_d;
        logic [POS_W-1:0]   out_h;
        logic [POS_W-1:0]   out_w;
    } coord_t;

    // Source coordinate and linear offset expected on the output channel
    typedef struct packed {
        logic [SRC_W-1:0] pos_d;
        logic [SRC_W-1:0] pos_h;
        logic [SRC_W-1:0] pos_w;
        logic [OFF_W-1:0] src_off;
    } src_addr_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    padsag_in_if  in_ch ();
    padsag_out_if out_ch ();

    pad_source_address_gen_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Local copy of the register file; axis 0 depth, 1 height, 2 width
    logic                  cfg_reflect;
    logic [EXT_W-1:0]      cfg_pad [3];
    logic [EXT_W-1:0]      cfg_ext [3];

    src_addr_t             pending_addrs [$];
    src_addr_t             head_addr;
    int                    fail_count = 0;
    int                    idle_cycles = 0;
    bit                    tx_throttle = 1'b1;
    bit                    rx_throttle = 1'b1;
    int                    rx_hold_len = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Zero extent counts as one, oversize saturates
    function automatic int eff_extent(logic [EXT_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > MAX_EXTENT) begin
            return MAX_EXTENT;
        end
        return int'(v);
    endfunction

    // Map one output position to its source position along one axis
    function automatic int map_pos(int j, int size, int pad, bit reflect);
        int i;
        if (j < pad) begin
            i = reflect ? 2 * pad - j : pad;
        end else if (j < size + pad) begin
            i = j;
        end else begin
            i = reflect ? 2 * (size + pad - 1) - j : size + pad - 1;
        end
        // drop the leading pad; a negative pad crops
        i = i - pad;
        if (i < 0) begin
            i = 0;
        end
        if (i > size - 1) begin
            i = size - 1;
        end
        return i;
    endfunction

    function automatic src_addr_t predict_src(coord_t c);
        src_addr_t         r;
        int                ext [3];
        int                pos [3];
        int                src [3];
        longint unsigned   off;
        pos[0] = int'(c.out_d);
        pos[1] = int'(c.out_h);
        pos[2] = int'(c.out_w);
        for (int a = 0; a < 3; a++) begin
            ext[a] = eff_extent(cfg_ext[a]);
            src[a] = map_pos(pos[a], ext[a], int'($signed(cfg_pad[a])), cfg_reflect);
        end
        off = 64'(c.plane) * 64'(ext[0]) * 64'(ext[1]) * 64'(ext[2])
            + 64'(src[0]) * 64'(ext[1]) * 64'(ext[2])
            + 64'(src[1]) * 64'(ext[2])
            + 64'(src[2]);
        r.pos_d   = SRC_W'(src[0]);
        r.pos_h   = SRC_W'(src[1]);
        r.pos_w   = SRC_W'(src[2]);
        r.src_off = OFF_W'(off);
        return r;
    endfunction

    function automatic coord_t mk_coord(int plane, int d, int h, int w);
        coord_t c;
        c.plane = PLANE_W'(plane);
        c.out_d = POS_W'(d);
        c.out_h = POS_W'(h);
        c.out_w = POS_W'(w);
        return c;
    endfunction

    // Sender gap: mostly none or short, now and then long
    function automatic int tx_gap();
        int r;
        if (!tx_throttle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic int rx_stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one item, wait for acceptance, record its expected address
    task automatic send_coord(coord_t c);
        int gap;
        in_ch.valid          <= 1'b1;
        in_ch.plane          <= c.plane;
        in_ch.out_depth_pos  <= c.out_d;
        in_ch.out_height_pos <= c.out_h;
        in_ch.out_width_pos  <= c.out_w;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        pending_addrs.push_back(predict_src(c));
        gap = tx_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_addrs.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_PAD_MODE:   cfg_reflect = data[0];
            CFG_PAD_DEPTH:  cfg_pad[0]  = data;
            CFG_PAD_HEIGHT: cfg_pad[1]  = data;
            CFG_PAD_WIDTH:  cfg_pad[2]  = data;
            CFG_SRC_DEPTH:  cfg_ext[0]  = data;
            CFG_SRC_HEIGHT: cfg_ext[1]  = data;
            CFG_SRC_WIDTH:  cfg_ext[2]  = data;
            default: ;
        endcase
    endtask

    // Rewrite every register once the pipeline is empty
    task automatic set_config(logic mode, int pd, int ph, int pw, int ed, int eh, int ew);
        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
        write_reg(CFG_PAD_MODE,   CFG_DATA_W'(mode));
        write_reg(CFG_PAD_DEPTH,  CFG_DATA_W'(pd));
        write_reg(CFG_PAD_HEIGHT, CFG_DATA_W'(ph));
        write_reg(CFG_PAD_WIDTH,  CFG_DATA_W'(pw));
        write_reg(CFG_SRC_DEPTH,  CFG_DATA_W'(ed));
        write_reg(CFG_SRC_HEIGHT, CFG_DATA_W'(eh));
        write_reg(CFG_SRC_WIDTH,  CFG_DATA_W'(ew));
        i_cfg_we <= 1'b0;
        // H*W and then D*H*W are registered after the last write; let them settle
        repeat (4) @(posedge i_clk);
    endtask

    // Random extent: mostly small, sometimes zero or oversize
    function automatic int rand_extent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 0;
        if (r < 15) return $urandom_range(MAX_EXTENT + 1, 2047);
        if (r < 20) return MAX_EXTENT;
        return $urandom_range(1, 12);
    endfunction

    // Random pad around the extent, with full-range and extreme values mixed in
    function automatic int rand_pad(int ext_raw);
        int r;
        int s;
        s = eff_extent(EXT_W'(ext_raw));
        if (s > 16) s = 16;
        r = $urandom_range(0, 99);
        if (r < 10) return int'($urandom_range(0, 2047)) - 1024;
        if (r < 15) return ($urandom_range(0, 1) != 0) ? 1023 : -1024;
        return int'($urandom_range(0, 2 * s + 4)) - (s + 2);
    endfunction

    // Position mostly within the padded extent, sometimes anywhere
    function automatic int rand_pos(int axis);
        int s;
        int p;
        int top;
        s = eff_extent(cfg_ext[axis]);
        p = int'($signed(cfg_pad[axis]));
        if ($urandom_range(0, 99) < 15) begin
            return $urandom_range(0, 4095);
        end
        top = s + 2 * ((p > 0) ? p : 0) + 2;
        if (top > 4095) top = 4095;
        return $urandom_range(0, top);
    endfunction

    function automatic coord_t rand_coord();
        int plane;
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) plane = 0;
        else if (r < 10) plane = 65535;
        else plane = $urandom_range(0, 65535);
        return mk_coord(plane, rand_pos(0), rand_pos(1), rand_pos(2));
    endfunction

    // Defaults after reset: every extent one, so the offset is the plane
    task automatic test_reset_values();
        send_coord(mk_coord(0, 0, 0, 0));
        send_coord(mk_coord(65535, 4095, 4095, 4095));
        send_coord(mk_coord(16'h5555, 12'haaa, 12'h555, 12'hfff));
        send_coord(mk_coord(16'haaaa, 12'h555, 12'haaa, 0));
    endtask

    // Replicate: before, at and past both edges
    task automatic test_replicate_edges();
        set_config(MODE_REPLICATE, 2, 3, -1, 4, 5, 6);
        send_coord(mk_coord(1, 0, 0, 0));
        send_coord(mk_coord(2, 1, 2, 1));
        send_coord(mk_coord(3, 5, 7, 4));
        send_coord(mk_coord(4, 6, 8, 4095));
    endtask

    // Reflect, including a pad not smaller than the extent
    task automatic test_reflect_edges();
        set_config(MODE_REFLECT, 2, 4, 0, 5, 3, 1);
        send_coord(mk_coord(7, 0, 0, 0));
        send_coord(mk_coord(8, 2, 4, 1));
        send_coord(mk_coord(9, 6, 6, 2));
        send_coord(mk_coord(10, 8, 9, 4095));
    endtask

    // Negative pads crop, down to the most negative value
    task automatic test_negative_pads();
        set_config(MODE_REFLECT, -3, -1023, -1024, 8, 1024, 2047);
        send_coord(mk_coord(0, 0, 0, 0));
        send_coord(mk_coord(100, 4, 1, 1));
        send_coord(mk_coord(200, 5, 4095, 2047));
        set_config(MODE_REPLICATE, -3, -1023, -1024, 8, 1024, 2047);
        send_coord(mk_coord(300, 4095, 2, 4095));
    endtask

    // Zero and oversize extents, largest pads, largest offset
    task automatic test_extent_limits();
        set_config(MODE_REPLICATE, 0, 0, 0, 2047, MAX_EXTENT, 2047);
        send_coord(mk_coord(65535, 4095, 4095, 4095));
        send_coord(mk_coord(65535, 1023, 1023, 1023));
        set_config(MODE_REFLECT, 1023, -1024, 1023, 0, 0, 0);
        send_coord(mk_coord(12345, 0, 4095, 1023));
        send_coord(mk_coord(65535, 1024, 0, 2046));
    endtask

    // Receiver holds off while items keep coming; then drain fully
    task automatic test_output_stall();
        set_config(MODE_REFLECT, 1, 2, 0, 6, 3, 9);
        tx_throttle = 1'b0;
        rx_hold_len = 150;
        repeat (30) send_coord(rand_coord());
        in_ch.valid <= 1'b0;
        wait_drained();
        tx_throttle = 1'b1;
    endtask

    // Many random configurations, each with a burst of items
    task automatic test_random_configs();
        int ed;
        int eh;
        int ew;
        for (int ph = 0; ph < 20; ph++) begin
            ed = rand_extent();
            eh = rand_extent();
            ew = rand_extent();
            set_config(1'($urandom_range(0, 1)), rand_pad(ed), rand_pad(eh), rand_pad(ew),
                       ed, eh, ew);
            // every fifth burst runs without idling on either side
            tx_throttle = (ph % 5 != 2);
            rx_throttle = (ph % 5 != 2);
            repeat (40) send_coord(rand_coord());
        end
        tx_throttle = 1'b1;
        rx_throttle = 1'b1;
    endtask

    // Stimulus and final verdict
    initial begin
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= CFG_PAD_MODE;
        i_cfg_data           <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.plane          <= '0;
        in_ch.out_depth_pos  <= '0;
        in_ch.out_height_pos <= '0;
        in_ch.out_width_pos  <= '0;
        cfg_reflect = MODE_REPLICATE;
        for (int a = 0; a < 3; a++) begin
            cfg_pad[a] = '0;
            cfg_ext[a] = EXT_W'(1);
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_replicate_edges();
        test_reflect_edges();
        test_negative_pads();
        test_extent_limits();
        test_output_stall();
        test_random_configs();

        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Output ready: random stalls, requested long holds, or always ready
    initial begin
        int hold;
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) begin
            @(posedge i_clk);
        end
        forever begin
            if (rx_hold_len > 0) begin
                hold = rx_hold_len;
                rx_hold_len = 0;
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else if (rx_throttle && $urandom_range(0, 99) < 30) begin
                out_ch.ready <= 1'b0;
                repeat (rx_stall_len()) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
            end
        end
    endtask

    // Compare each accepted result with the oldest pending address
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_addrs.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected item: offset %0d", out_ch.src_offset);
                end
            end else begin
                head_addr = pending_addrs.pop_front();
                check_field("src_depth_pos", 64'(head_addr.pos_d),
                            64'(out_ch.src_depth_pos));
                check_field("src_height_pos", 64'(head_addr.pos_h),
                            64'(out_ch.src_height_pos));
                check_field("src_width_pos", 64'(head_addr.pos_w),
                            64'(out_ch.src_width_pos));
                check_field("src_offset", 64'(head_addr.src_off),
                            64'(out_ch.src_offset));
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
